[rtl/svap_pkg.sv]
// shared constants, codes and types for the servo angle to pulse mapper
package svap_pkg;

    // number of logical servo channels held in the calibration memory
    localparam int CHANNELS = 16;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // a set-all command reports at most sixteen channels
    localparam int MAX_REPORTS = 16;
    localparam int REPORT_COUNT = (CHANNELS < MAX_REPORTS) ? CHANNELS : MAX_REPORTS;

    localparam logic [7:0] ANGLE_LIMIT = 8'd180;

    // stream payload widths
    localparam int IN_TDATA_W = 72;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    // divider sizes: angle offset times pulse span over angle span
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W = 8;
    localparam int QUOT_W = 16;
    localparam int DIV_CNT_W = $clog2(DIVIDEND_W);

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_SET_ONE = 2'd1,
        ACT_SET_ALL = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ANGLE   = 2'd1,
        STATUS_CHANNEL = 2'd2,
        STATUS_LIMITS  = 2'd3
    } status_t;

    // one calibration entry, 53 bits
    typedef struct packed {
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
        logic        reversed;
        logic [3:0]  out_channel;
    } cal_entry_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_resp_t;

endpackage

[rtl/svap_div.sv]
// restoring serial divider, one quotient bit per cycle
module svap_div (
    input  logic                clk,
    input  logic                rst_n,
    input  svap_pkg::div_req_t  req,
    output svap_pkg::div_resp_t resp
);

    localparam int DW = svap_pkg::DIVIDEND_W;
    localparam int SW = svap_pkg::DIVISOR_W;
    localparam int CW = svap_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] quo_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] dsr_reg;

    logic [SW:0]   rem_shift;
    logic          fits;
    logic [SW-1:0] rem_next;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DW-1]};
        fits = (rem_shift >= {1'b0, dsr_reg});
        if (fits)
        begin
            rem_next = SW'(rem_shift - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = rem_shift[SW-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(DW - 1));
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign resp.busy     = busy_reg;
    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg[svap_pkg::QUOT_W-1:0];

    // partial remainder always stays below the divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder reached the divisor");

    // a start while idle always begins an iteration run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

    // the quotient always fits in sixteen bits, the width of the pulse span
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (quo_reg[DW-1:svap_pkg::QUOT_W] == '0))
        else $error("divider quotient overflowed sixteen bits");

endmodule

[rtl/servo_angle_to_pulse_core.sv]
// top level: calibration memory, command sequencer and pulse mapping datapath
//
// Usage
//   Input items arrive on the s_ stream. s_tuser carries the action: write one
//   calibration entry, set one channel to an angle, or set all channels. Results
//   leave on the m_ stream, m_tlast marking the final result of an input item.
//   Calibration entries live in a 16-deep synchronous memory; a valid flag per
//   entry makes an unwritten entry read as all zero.
//   A table write or a rejected command goes from acceptance straight to the
//   output stage. A mapped channel passes one memory read, one step of
//   clamping, one multiply, then the bit-serial divider. A set-all command
//   repeats that for each reported channel. Action code 3 is taken and gives
//   nothing. One item is worked on at a time; s_tready is high while the
//   sequencer is idle, also while an earlier result still waits in the output
//   register. Reset clears every calibration entry (through the valid flags)
//   and empties the output register. While m_tready is low the finished
//   result holds and the sequencer waits before loading the next one.
module servo_angle_to_pulse_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // channel[7:0], angle[15:8], cal_min_angle[23:16], cal_max_angle[31:24],
    // cal_min_pulse[47:32], cal_max_pulse[63:48], cal_reversed[64],
    // cal_out_channel[68:65], zero fill[71:69]
    input  logic [svap_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [svap_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // servo_index[7:0], pwm_channel[11:8], clamped_angle[19:12],
    // pulse_width[35:20], zero fill[39:36]
    output logic [svap_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status[1:0], all_ok[2]
    output logic [svap_pkg::OUT_TUSER_W-1:0]  m_tuser,
    output logic                               m_tlast
);

    localparam int CW = svap_pkg::CH_W;
    localparam logic [8:0] CHAN_LIMIT = 9'(svap_pkg::CHANNELS);
    localparam logic [CW-1:0] LAST_IDX = CW'(svap_pkg::REPORT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAP,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        svap_pkg::status_t status;
        logic [7:0]        servo_index;
        logic [3:0]        pwm_channel;
        logic [7:0]        clamped_angle;
        logic [15:0]       pulse_width;
        logic              all_ok;
        logic              last;
    } result_t;

    // input fields
    logic [7:0]          in_channel;
    logic [7:0]          in_angle;
    svap_pkg::cal_entry_t in_entry;
    svap_pkg::action_t   in_action;
    logic                in_accept;
    logic                chan_ok;
    logic                angle_bad;

    assign in_channel           = s_tdata[7:0];
    assign in_angle             = s_tdata[15:8];
    assign in_entry.min_angle   = s_tdata[23:16];
    assign in_entry.max_angle   = s_tdata[31:24];
    assign in_entry.min_pulse   = s_tdata[47:32];
    assign in_entry.max_pulse   = s_tdata[63:48];
    assign in_entry.reversed    = s_tdata[64];
    assign in_entry.out_channel = s_tdata[68:65];
    assign in_action            = svap_pkg::action_t'(s_tuser);

    state_t state_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign chan_ok   = ({1'b0, in_channel} < CHAN_LIMIT);
    assign angle_bad = (in_angle > svap_pkg::ANGLE_LIMIT);

    // calibration memory with per-entry valid flags
    svap_pkg::cal_entry_t cal_mem [svap_pkg::CHANNELS];
    logic [svap_pkg::CHANNELS-1:0] valid_reg;
    svap_pkg::cal_entry_t rd_data_reg;
    logic                 rd_hit_reg;
    logic                 mem_we;
    logic [CW-1:0]        idx_reg;

    assign mem_we = in_accept && (in_action == svap_pkg::ACT_WRITE) && chan_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cal_mem[in_channel[CW-1:0]] <= in_entry;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= cal_mem[idx_reg];
            rd_hit_reg  <= valid_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[in_channel[CW-1:0]] <= 1'b1;
        end
    end

    // clamp, mirror and span of the entry just read
    svap_pkg::cal_entry_t ent;
    logic [7:0]  angle_reg;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  a_clamp;
    logic [7:0]  ang_off;
    logic [7:0]  ang_span;
    logic        limits_bad;
    logic        pulse_neg;
    logic [15:0] pulse_span;

    always_comb
    begin
        ent = rd_hit_reg ? rd_data_reg : '0;
        lo  = ent.min_angle;
        hi  = ent.max_angle;
        limits_bad = (lo > hi);
        if (angle_reg < lo)
        begin
            a_clamp = lo;
        end
        else if (angle_reg > hi)
        begin
            a_clamp = hi;
        end
        else
        begin
            a_clamp = angle_reg;
        end
        ang_off  = ent.reversed ? (hi - a_clamp) : (a_clamp - lo);
        ang_span = hi - lo;
        pulse_neg = (ent.max_pulse < ent.min_pulse);
        pulse_span = pulse_neg ? (ent.min_pulse - ent.max_pulse)
                               : (ent.max_pulse - ent.min_pulse);
    end

    // mapping datapath registers
    logic [7:0]  mul_a_reg;
    logic [15:0] mul_b_reg;
    logic [7:0]  den_reg;
    logic [15:0] min_pulse_reg;
    logic        neg_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            angle_reg <= in_angle;
        end
        if (state_reg == ST_MAP)
        begin
            mul_a_reg     <= ang_off;
            mul_b_reg     <= pulse_span;
            den_reg       <= ang_span;
            min_pulse_reg <= ent.min_pulse;
            neg_reg       <= pulse_neg;
        end
    end

    // divider: product registered into the divider at start
    svap_pkg::div_req_t  div_req;
    svap_pkg::div_resp_t div_resp;

    assign div_req.start    = (state_reg == ST_MUL);
    assign div_req.dividend = svap_pkg::DIVIDEND_W'(mul_a_reg)
                            * svap_pkg::DIVIDEND_W'(mul_b_reg);
    assign div_req.divisor  = den_reg;

    svap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    logic [15:0] pulse_mapped;
    assign pulse_mapped = neg_reg ? (min_pulse_reg - div_resp.quotient)
                                  : (min_pulse_reg + div_resp.quotient);

    // sequencer and output register
    result_t res_reg;
    result_t res_in;
    result_t m_res_reg;
    logic    m_valid_reg;
    logic    set_all_reg;
    logic    all_reg;
    logic    is_last;
    logic    out_load;

    assign is_last  = !set_all_reg || (idx_reg == LAST_IDX);
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // first result of an accepted item, final for writes and rejects
    always_comb
    begin
        res_in             = '0;
        res_in.servo_index = in_channel;
        res_in.last        = 1'b1;
        case (in_action)
            svap_pkg::ACT_WRITE:
            begin
                if (chan_ok)
                begin
                    res_in.status      = svap_pkg::STATUS_OK;
                    res_in.pwm_channel = in_entry.out_channel;
                    res_in.all_ok      = 1'b1;
                end
                else
                begin
                    res_in.status = svap_pkg::STATUS_CHANNEL;
                end
            end
            svap_pkg::ACT_SET_ONE:
            begin
                if (angle_bad)
                begin
                    res_in.status = svap_pkg::STATUS_ANGLE;
                end
                else if (!chan_ok)
                begin
                    res_in.status = svap_pkg::STATUS_CHANNEL;
                end
            end
            svap_pkg::ACT_SET_ALL:
            begin
                res_in.servo_index = '0;
                if (angle_bad)
                begin
                    res_in.status = svap_pkg::STATUS_ANGLE;
                end
            end
            default:
            begin
                res_in.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            set_all_reg <= 1'b0;
            all_reg     <= 1'b0;
            res_reg     <= '0;
            m_res_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= out_load || (m_valid_reg && !m_tready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        res_reg <= res_in;
                        all_reg <= 1'b1;
                        case (in_action)
                            svap_pkg::ACT_WRITE:
                            begin
                                state_reg <= ST_EMIT;
                            end
                            svap_pkg::ACT_SET_ONE:
                            begin
                                set_all_reg <= 1'b0;
                                idx_reg     <= in_channel[CW-1:0];
                                if (angle_bad || !chan_ok)
                                begin
                                    state_reg <= ST_EMIT;
                                end
                                else
                                begin
                                    state_reg <= ST_READ;
                                end
                            end
                            svap_pkg::ACT_SET_ALL:
                            begin
                                idx_reg <= '0;
                                if (angle_bad)
                                begin
                                    set_all_reg <= 1'b0;
                                    state_reg   <= ST_EMIT;
                                end
                                else
                                begin
                                    set_all_reg <= 1'b1;
                                    state_reg   <= ST_READ;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MAP;
                end
                ST_MAP:
                begin
                    res_reg.servo_index <= 8'(idx_reg);
                    res_reg.pwm_channel <= ent.out_channel;
                    res_reg.last        <= is_last;
                    if (limits_bad)
                    begin
                        res_reg.status        <= svap_pkg::STATUS_LIMITS;
                        res_reg.clamped_angle <= '0;
                        res_reg.pulse_width   <= '0;
                        res_reg.all_ok        <= 1'b0;
                        all_reg               <= 1'b0;
                        state_reg             <= ST_EMIT;
                    end
                    else
                    begin
                        res_reg.status        <= svap_pkg::STATUS_OK;
                        res_reg.clamped_angle <= a_clamp;
                        res_reg.all_ok        <= is_last && all_reg;
                        if (hi == lo)
                        begin
                            res_reg.pulse_width <= ent.min_pulse;
                            state_reg           <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_resp.done)
                    begin
                        res_reg.pulse_width <= pulse_mapped;
                        state_reg           <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        m_res_reg <= res_reg;
                        if (set_all_reg && !res_reg.last)
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {4'b0000, m_res_reg.pulse_width, m_res_reg.clamped_angle,
                       m_res_reg.pwm_channel, m_res_reg.servo_index};
    assign m_tuser  = {m_res_reg.all_ok, m_res_reg.status};

    // a failed result carries no angle and no pulse
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] != svap_pkg::STATUS_OK))
        |-> ((m_tdata[35:20] == '0) && (m_tdata[19:12] == '0)))
        else $error("failed result carries a pulse or angle");

    // all_ok is only ever reported on the final result of an item
    a_all_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !m_tuser[2])
        else $error("all_ok set on a result that is not the last");

    // the divider is free and the angle span nonzero whenever a new product is handed over
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (!div_resp.busy && (den_reg != '0)))
        else $error("divider started while busy or with zero span");

endmodule
